// ===== rtl/slsd_pkg.sv =====
// ----------------------------------------------------------------------------
// slsd_pkg
// shared types and constants of the sync / length / sum packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package slsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned SUM_W    = 8;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h10;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END_GOOD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END_BAD  = 2'd2;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_LEN_HI  = 5'b00010,
        PH_LEN_LO  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  packet_length;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/slsd_core.sv =====
// ----------------------------------------------------------------------------
// slsd_core
// framing state, length capture and running sum; when in_fire is high, one byte per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module slsd_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [slsd_pkg::BYTE_W-1:0]   cfg_wdata,
    input  wire logic                          in_fire,
    input  wire logic [slsd_pkg::BYTE_W-1:0]   rx_byte,
    output logic                               res_valid,
    output slsd_pkg::result_t                  res
);
    import slsd_pkg::*;

    logic [BYTE_W-1:0] sync_byte_reg;
    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  seen_reg, seen_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [LEN_W-1:0]  seen_inc;
    logic [LEN_W-1:0]  length_full;

    assign seen_inc    = seen_reg + LEN_W'(1);
    assign length_full = {length_reg[LEN_W-1:BYTE_W], rx_byte};

    always_comb
    begin
        phase_next        = phase_reg;
        length_next       = length_reg;
        seen_next         = seen_reg;
        sum_next          = sum_reg;
        res_valid         = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = '0;
        res.packet_length = length_reg;
        unique case (phase_reg)
            PH_LEN_HI:
            begin
                length_next = {rx_byte, {BYTE_W{1'b0}}};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = length_full;
                seen_next   = '0;
                sum_next    = '0;
                phase_next  = (length_full == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_next         = sum_reg + rx_byte;
                seen_next        = seen_inc;
                if (seen_inc == length_reg)
                    phase_next = PH_CHECK;
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
            end
            PH_CHECK:
            begin
                res_valid  = 1'b1;
                res.kind   = (rx_byte == sum_reg) ? KIND_END_GOOD : KIND_END_BAD;
                phase_next = PH_HUNT;
            end
            default:
            begin
                // hunt, and recovery from any illegal code
                phase_next = (rx_byte == sync_byte_reg) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg <= SYNC_RESET;
            phase_reg     <= PH_HUNT;
            length_reg    <= '0;
            seen_reg      <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                sync_byte_reg <= cfg_wdata;
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                length_reg <= length_next;
                seen_reg   <= seen_next;
                sum_reg    <= sum_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sync_length_sum_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_length_sum_deframer_unit
// deframes a byte stream of sync / 16-bit length / payload / sum-checksum packets
// ----------------------------------------------------------------------------
// input channel: one received byte per transaction (in_valid, in_stall, rx_byte).
// bytes are dropped until cfg sync byte is seen, then a big-endian length,
// the payload bytes and a checksum byte follow.
// output channel: one transaction per payload byte (kind 0) and one end
// transaction per packet (kind 1 good sum, kind 2 bad sum); packet_length
// carries the declared length. downstream must drop packets that end bad, as
// the unit does not. sync, length and hunted bytes give no output transaction.
// a result is registered in the result register, or in the skid register while
// another result waits. throughput: one byte per cycle while in_stall is low.
// a two-entry output buffer (result register plus skid register) lets a new
// byte be taken while a result waits; in_stall rises only once both entries
// are full, and is driven from a register alone.
// reset: hunting for sync, sync byte 0x10, output buffer empty.
// cfg_we writes the sync byte; it is used at the next hunt.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_sum_deframer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [slsd_pkg::BYTE_W-1:0]   cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [slsd_pkg::BYTE_W-1:0]   rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [slsd_pkg::KIND_W-1:0]        kind,
    output logic [slsd_pkg::BYTE_W-1:0]        payload_byte,
    output logic [slsd_pkg::LEN_W-1:0]         packet_length
);
    import slsd_pkg::*;

    logic    in_fire;
    logic    res_valid;
    result_t res;
    logic    push;
    logic    pop;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign push     = in_fire && res_valid;
    assign pop      = out_valid_reg && !out_stall;

    slsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                // input is stalled, only drain
                if (pop)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (!out_valid_reg || pop)
            begin
                out_valid_reg <= push;
            end
            else
            begin
                if (push)
                    skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || pop)
        begin
            if (push)
                out_reg <= res;
        end
        else
        begin
            if (push)
                skid_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign payload_byte  = out_reg.payload_byte;
    assign packet_length = out_reg.packet_length;

endmodule

`default_nettype wire
